// ===== rtl/core/ordered_list_table_engine_assert.svh =====
// Assertion helpers used by the olte_seq sequencer.
// All checks sample on clk_i and stay quiet while rst_ni is low.
`ifndef ORDERED_LIST_TABLE_ENGINE_ASSERT_SVH
`define ORDERED_LIST_TABLE_ENGINE_ASSERT_SVH

// Plain property check.
`define OLTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define OLTE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OLTE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/olte_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package olte_pkg;

  localparam int unsigned CAPACITY_DEF   = 256;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed field widths of the request and result transfers
  localparam int unsigned KIND_W = 3;
  localparam int unsigned POS_W  = 9;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT   = 3'd0,
    KIND_DELETE   = 3'd1,
    KIND_RETRIEVE = 3'd2,
    KIND_LOCATE   = 3'd3,
    KIND_CLEAR    = 3'd4
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_MISS   = 2'd1,
    STAT_BADPOS = 2'd2
  } status_e;

  // Memory strobes from the sequencer to the element store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // One result item
  typedef struct packed {
    status_e                  status;
    logic signed [VAL_W-1:0]  read_value;
    logic        [POS_W-1:0]  found_position;
    logic        [POS_W-1:0]  list_length;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/olte_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Request channel
interface olte_req_if;
  import olte_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

// Result channel
interface olte_rsp_if;
  import olte_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] read_value;
  logic [POS_W-1:0]        found_position;
  logic [POS_W-1:0]        list_length;

  modport source (output valid, status, read_value, found_position, list_length,
                  input ready);
  modport sink   (input valid, status, read_value, found_position, list_length,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ordered_list_table_engine.sv =====
// Flow: clear and rejected requests go straight to the output register; retrieve reads one entry;
//   insert and delete shift the entries behind the position, one entry per cycle, then finish;
//   locate scans from the head until the hit, or over every entry on a miss.
// Throughput: one request at a time; the next transfer is taken only after the result loads,
//   so a long memory walk holds off the next request.
// Reset: list length and result register clear; memory contents stay undefined, no sweep.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_table_engine #(
  parameter int unsigned CAPACITY   = olte_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = olte_pkg::DATA_WIDTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  olte_req_if.sink    req_i,
  olte_rsp_if.source  rsp_o
);
  import olte_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);

  mem_ctl_t              mem_ctl;
  logic [AW-1:0]         mem_raddr;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] mem_rdata;
  rsp_t                  rsp;
  logic                  rsp_valid;
  logic                  rsp_ready;

  // Request decode and memory walk
  olte_seq #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .mem_ctl_o   (mem_ctl),
    .mem_raddr_o (mem_raddr),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata),
    .rsp_o       (rsp),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready)
  );

  // Element memory
  olte_store #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk_i     (clk_i),
    .mem_ctl_i (mem_ctl),
    .raddr_i   (mem_raddr),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .rdata_o   (mem_rdata)
  );

  // Result register
  olte_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rsp_i       (rsp),
    .rsp_valid_i (rsp_valid),
    .rsp_ready_o (rsp_ready),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/olte_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module olte_store #(
  parameter int unsigned CAPACITY   = olte_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = olte_pkg::DATA_WIDTH_DEF,
  localparam int unsigned AW        = $clog2(CAPACITY)
) (
  input  wire                     clk_i,
  input  wire olte_pkg::mem_ctl_t mem_ctl_i,
  input  wire  [AW-1:0]           raddr_i,
  input  wire  [AW-1:0]           waddr_i,
  input  wire  [DATA_WIDTH-1:0]   wdata_i,
  output logic [DATA_WIDTH-1:0]   rdata_o
);
  import olte_pkg::*;

  logic [DATA_WIDTH-1:0] mem_q [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/olte_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_list_table_engine_assert.svh"

module olte_seq #(
  parameter int unsigned CAPACITY   = olte_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = olte_pkg::DATA_WIDTH_DEF,
  localparam int unsigned AW        = $clog2(CAPACITY),
  localparam int unsigned CW        = $clog2(CAPACITY + 1)
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  olte_req_if.sink                req_i,
  output olte_pkg::mem_ctl_t      mem_ctl_o,
  output logic [AW-1:0]           mem_raddr_o,
  output logic [AW-1:0]           mem_waddr_o,
  output logic [DATA_WIDTH-1:0]   mem_wdata_o,
  input  wire  [DATA_WIDTH-1:0]   mem_rdata_i,
  output olte_pkg::rsp_t          rsp_o,
  output logic                    rsp_valid_o,
  input  wire                     rsp_ready_i
);
  import olte_pkg::*;

  // Compare width covering both the position field and the length
  localparam int unsigned PW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_DONE
  } state_e;

  state_e                state_q, state_d;
  kind_e                 op_q, op_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [AW-1:0]         cur_q, cur_d;
  logic [CW-1:0]         rem_q, rem_d;
  logic                  pend_q, pend_d;
  logic [AW-1:0]         paddr_q, paddr_d;
  logic [AW-1:0]         ins_q, ins_d;
  rsp_t                  res_q, res_d;

  logic [PW-1:0] pos_w;
  logic [PW-1:0] cnt_w;
  logic [PW-1:0] pm1_w;
  logic          fin;

  assign pos_w = PW'(req_i.position);
  assign cnt_w = PW'(cnt_q);
  assign pm1_w = pos_w - PW'(1);

  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_o       = res_q;

  // Decode requests and walk the store one entry per cycle
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    val_d       = val_q;
    cur_d       = cur_q;
    rem_d       = rem_q;
    pend_d      = 1'b0;
    paddr_d     = paddr_q;
    ins_d       = ins_q;
    res_d       = res_q;
    fin         = 1'b0;
    mem_ctl_o   = '0;
    mem_raddr_o = cur_q;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    rsp_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          op_d    = kind_e'(req_i.kind);
          val_d   = DATA_WIDTH'($unsigned(req_i.value));
          res_d   = '0;
          res_d.status = STAT_MISS;
          state_d = ST_DONE;
          unique case (kind_e'(req_i.kind))
            KIND_INSERT: begin
              if (pos_w == '0 || pos_w > cnt_w + PW'(1)) begin
                res_d.status = STAT_BADPOS;
              end else if (cnt_w == PW'(CAPACITY)) begin
                res_d.status = STAT_MISS;
              end else begin
                cnt_d   = cnt_q + CW'(1);
                cur_d   = AW'(cnt_w - PW'(1));
                rem_d   = CW'(cnt_w - pm1_w);
                ins_d   = AW'(pm1_w);
                state_d = ST_WORK;
              end
            end
            KIND_DELETE: begin
              if (pos_w == '0 || pos_w > cnt_w) begin
                res_d.status = STAT_BADPOS;
              end else begin
                cnt_d   = cnt_q - CW'(1);
                cur_d   = AW'(pos_w);
                rem_d   = CW'(cnt_w - pos_w);
                state_d = ST_WORK;
              end
            end
            KIND_RETRIEVE: begin
              if (pos_w != '0 && pos_w <= cnt_w) begin
                cur_d   = AW'(pm1_w);
                rem_d   = CW'(1);
                state_d = ST_WORK;
              end
            end
            KIND_LOCATE: begin
              cur_d   = '0;
              rem_d   = cnt_q;
              state_d = ST_WORK;
            end
            KIND_CLEAR: begin
              cnt_d        = '0;
              res_d.status = STAT_OK;
            end
            default: begin
              res_d.status = STAT_MISS;
            end
          endcase
          res_d.list_length = POS_W'(cnt_d);
        end
      end

      ST_WORK: begin
        // Consume the entry read in the previous cycle
        if (pend_q) begin
          unique case (op_q)
            KIND_INSERT: begin
              mem_ctl_o.wr_en = 1'b1;
              mem_waddr_o     = paddr_q + AW'(1);
              mem_wdata_o     = mem_rdata_i;
            end
            KIND_DELETE: begin
              mem_ctl_o.wr_en = 1'b1;
              mem_waddr_o     = paddr_q - AW'(1);
              mem_wdata_o     = mem_rdata_i;
            end
            KIND_LOCATE: begin
              if (mem_rdata_i == val_q) begin
                fin                  = 1'b1;
                res_d.status         = STAT_OK;
                res_d.found_position = POS_W'(CW'(paddr_q) + CW'(1));
              end
            end
            KIND_RETRIEVE: begin
              fin              = 1'b1;
              res_d.status     = STAT_OK;
              res_d.read_value = VAL_W'($signed(mem_rdata_i));
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end else if (rem_q == '0) begin
          // Walk finished: place the new element, complete a delete, or report the miss
          fin = 1'b1;
          unique case (op_q)
            KIND_INSERT: begin
              mem_ctl_o.wr_en = 1'b1;
              mem_waddr_o     = ins_q;
              mem_wdata_o     = val_q;
              res_d.status    = STAT_OK;
            end
            KIND_DELETE: begin
              res_d.status = STAT_OK;
            end
            default: begin
              res_d.status = STAT_MISS;
            end
          endcase
        end

        // Issue the next read of the walk
        if (!fin && rem_q != '0) begin
          mem_ctl_o.rd_en = 1'b1;
          mem_raddr_o     = cur_q;
          pend_d          = 1'b1;
          paddr_d         = cur_q;
          rem_d           = rem_q - CW'(1);
          cur_d           = (op_q == KIND_INSERT) ? cur_q - AW'(1) : cur_q + AW'(1);
        end

        if (fin) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        // Hand the result to the output register once it has room
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, length and work registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= KIND_CLEAR;
      cnt_q   <= '0;
      val_q   <= '0;
      cur_q   <= '0;
      rem_q   <= '0;
      pend_q  <= 1'b0;
      paddr_q <= '0;
      ins_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
      val_q   <= val_d;
      cur_q   <= cur_d;
      rem_q   <= rem_d;
      pend_q  <= pend_d;
      paddr_q <= paddr_d;
      ins_q   <= ins_d;
      res_q   <= res_d;
    end
  end

  `OLTE_ASSERT(a_len_bound, cnt_q <= CW'(CAPACITY), "list length beyond capacity")
  `OLTE_ASSERT_IMP(a_rw_apart, mem_ctl_o.rd_en && mem_ctl_o.wr_en, mem_raddr_o != mem_waddr_o, "read and write hit the same entry")
  `OLTE_ASSERT_NXT(a_accept_busy, req_i.valid && req_i.ready, state_q != ST_IDLE, "accepted request left no work")

endmodule

`default_nettype wire

// ===== rtl/core/olte_out.sv =====
`timescale 1ns / 1ps
`default_nettype none

module olte_out (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire olte_pkg::rsp_t rsp_i,
  input  wire                 rsp_valid_i,
  output logic                rsp_ready_o,
  olte_rsp_if.source          rsp_o
);
  import olte_pkg::*;

  logic valid_q;
  rsp_t data_q;

  // Room when empty or when the held result leaves this cycle
  assign rsp_ready_o = !valid_q || rsp_o.ready;

  // Hold the result until the sink takes the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      data_q  <= '0;
    end else if (rsp_ready_o) begin
      valid_q <= rsp_valid_i;
      if (rsp_valid_i) begin
        data_q <= rsp_i;
      end
    end
  end

  assign rsp_o.valid          = valid_q;
  assign rsp_o.status         = data_q.status;
  assign rsp_o.read_value     = data_q.read_value;
  assign rsp_o.found_position = data_q.found_position;
  assign rsp_o.list_length    = data_q.list_length;

endmodule

`default_nettype wire
